@@ hw/rtl/bgpw_pkg.sv @@
`default_nettype none

package bgpw_pkg;

    // request commands
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_FOUND     = 3'd0;
    localparam logic [2:0] KIND_SHORT_HDR = 3'd1;
    localparam logic [2:0] KIND_SHORT_PAY = 3'd2;
    localparam logic [2:0] KIND_DONE      = 3'd3;
    localparam logic [2:0] KIND_COUNT     = 3'd4;

    localparam int EXT_LEN_BIT    = 4;
    localparam int NUM_TYPES      = 256;
    localparam int TYPE_W         = 8;
    localparam int TYPE_COUNT_W   = 32;
    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_W      = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FLAGS,
        PH_TYPE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_SWALLOW
    } phase_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] area_length;
        logic [7:0]  data_byte;
    } req_item_t;

    typedef struct packed {
        logic [2:0]              kind;
        logic [7:0]              attr_type;
        logic [7:0]              attr_flags;
        logic [15:0]             attr_length;
        logic [15:0]             remaining_bytes;
        logic [TYPE_COUNT_W-1:0] type_count;
        logic                    last;
    } res_item_t;

    // counter memory operation
    typedef struct packed {
        logic              inc;
        logic              rd;
        logic [TYPE_W-1:0] addr;
    } cnt_op_t;

    // results of one request, waiting for the counter read to return
    typedef struct packed {
        logic [1:0] res_cnt;
        res_item_t  res0;
        res_item_t  res1;
    } stage_t;

endpackage

`default_nettype wire

@@ hw/rtl/bgpw_stream_if.sv @@
`default_nettype none

interface bgpw_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bgpw_ram.sv @@
`default_nettype none

module bgpw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

@@ hw/rtl/bgpw_parser.sv @@
`default_nettype none

module bgpw_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  bgpw_pkg::req_item_t item,
    output bgpw_pkg::cnt_op_t   op,
    output bgpw_pkg::stage_t    stage
);
    import bgpw_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] area_reg, area_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pay_reg, pay_next;
    stage_t      stage_reg, stage_next;

    logic [7:0]  b;
    logic        active;
    logic        ext;
    logic [15:0] area_dec;
    logic [15:0] need;
    logic        hdr_short;
    logic [15:0] len_full;
    logic        pay_short;
    logic [15:0] pay_dec;
    logic        area_end;

    res_item_t   done_item;
    res_item_t   first;
    logic        have_first;

    assign b         = item.data_byte;
    assign active    = accept && (item.command == CMD_DATA) && (phase_reg != PH_IDLE)
                       && (area_reg != 16'd0);
    assign ext       = flags_reg[EXT_LEN_BIT];
    assign area_dec  = area_reg - 16'd1;
    assign area_end  = (area_dec == 16'd0);
    assign need      = b[EXT_LEN_BIT] ? 16'd4 : 16'd3;
    assign hdr_short = (area_reg < need);
    assign len_full  = {len_reg[15:8], b};
    assign pay_short = (len_full > area_dec);
    assign pay_dec   = (pay_reg != 16'd0) ? (pay_reg - 16'd1) : pay_reg;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        area_next  = area_reg;
        flags_next = flags_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        pay_next   = pay_reg;
        if (accept && (item.command == CMD_BEGIN))
        begin
            area_next  = item.area_length;
            flags_next = '0;
            type_next  = '0;
            len_next   = '0;
            pay_next   = '0;
            phase_next = (item.area_length == 16'd0) ? PH_IDLE : PH_FLAGS;
        end
        else if (active)
        begin
            area_next = area_dec;
            case (phase_reg)
                PH_FLAGS:
                begin
                    flags_next = b;
                    phase_next = hdr_short ? PH_SWALLOW : PH_TYPE;
                end
                PH_TYPE:
                begin
                    type_next  = b;
                    len_next   = '0;
                    phase_next = ext ? PH_LEN_HI : PH_LEN_LO;
                end
                PH_LEN_HI:
                begin
                    len_next   = {b, 8'h00};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next = len_full;
                    if (pay_short)
                    begin
                        phase_next = PH_SWALLOW;
                    end
                    else
                    begin
                        pay_next   = len_full;
                        phase_next = (len_full != 16'd0) ? PH_PAYLOAD : PH_FLAGS;
                    end
                end
                PH_PAYLOAD:
                begin
                    pay_next = pay_dec;
                    if (pay_dec == 16'd0)
                    begin
                        phase_next = PH_FLAGS;
                    end
                end
                default:
                begin
                end
            endcase
            if (area_end)
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    // results and counter operation
    always_comb
    begin
        op         = '0;
        stage_next = '0;
        first      = '0;
        have_first = 1'b0;
        done_item  = '0;
        done_item.kind = KIND_DONE;
        done_item.last = 1'b1;
        if (accept && (item.command == CMD_BEGIN))
        begin
            if (item.area_length == 16'd0)
            begin
                stage_next.res_cnt = 2'd1;
                stage_next.res0    = done_item;
            end
        end
        else if (accept && (item.command == CMD_READ))
        begin
            op.rd   = 1'b1;
            op.addr = b;
            stage_next.res_cnt        = 2'd1;
            stage_next.res0.kind      = KIND_COUNT;
            stage_next.res0.attr_type = b;
            stage_next.res0.last      = 1'b1;
        end
        else if (active)
        begin
            case (phase_reg)
                PH_FLAGS:
                begin
                    if (hdr_short)
                    begin
                        have_first            = 1'b1;
                        first.kind            = KIND_SHORT_HDR;
                        first.attr_flags      = b;
                        first.remaining_bytes = area_reg;
                    end
                end
                PH_LEN_LO:
                begin
                    have_first        = 1'b1;
                    first.attr_type   = type_reg;
                    first.attr_flags  = flags_reg;
                    first.attr_length = len_full;
                    if (pay_short)
                    begin
                        first.kind            = KIND_SHORT_PAY;
                        first.remaining_bytes = area_dec + 16'd3 + {15'd0, ext};
                    end
                    else
                    begin
                        first.kind = KIND_FOUND;
                        op.inc     = 1'b1;
                        op.addr    = type_reg;
                    end
                end
                default:
                begin
                end
            endcase
            if (have_first)
            begin
                stage_next.res0 = first;
                if (area_end)
                begin
                    stage_next.res1    = done_item;
                    stage_next.res_cnt = 2'd2;
                end
                else
                begin
                    stage_next.res_cnt = 2'd1;
                end
            end
            else if (area_end)
            begin
                stage_next.res0    = done_item;
                stage_next.res_cnt = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            area_reg  <= '0;
            flags_reg <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            pay_reg   <= '0;
            stage_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            area_reg  <= area_next;
            flags_reg <= flags_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            pay_reg   <= pay_next;
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;
endmodule

`default_nettype wire

@@ hw/rtl/bgpw_cnt_bank.sv @@
`default_nettype none

module bgpw_cnt_bank #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bgpw_pkg::cnt_op_t                 op,
    output logic [bgpw_pkg::TYPE_COUNT_W-1:0] count
);
    import bgpw_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > TYPE_COUNT_W) ? COUNT_WIDTH : TYPE_COUNT_W;

    cnt_op_t                op_reg;
    logic [NUM_TYPES-1:0]   vld_reg;
    logic                   rd_vld_reg;
    logic                   wr_vld_reg;
    logic [TYPE_W-1:0]      wr_addr_reg;
    logic [COUNT_WIDTH-1:0] wr_data_reg;

    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] cur_val;
    logic [COUNT_WIDTH-1:0] wdata;
    logic                   we;
    logic                   re;
    logic [EXT_W-1:0]       cur_ext;

    assign re = op.inc || op.rd;
    assign we = op_reg.inc;

    // the write of the previous cycle is not yet visible in the read data
    assign cur_val = (wr_vld_reg && (wr_addr_reg == op_reg.addr)) ? wr_data_reg :
                     (rd_vld_reg ? ram_rdata : '0);
    assign wdata   = cur_val + COUNT_WIDTH'(1);
    assign cur_ext = EXT_W'(cur_val);
    assign count   = cur_ext[TYPE_COUNT_W-1:0];

    bgpw_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_TYPES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (op_reg.addr),
        .wdata (wdata),
        .re    (re),
        .raddr (op.addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= '0;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            wr_vld_reg <= 1'b0;
        end
        else
        begin
            op_reg     <= op;
            wr_vld_reg <= we;
            if (re)
            begin
                rd_vld_reg <= vld_reg[op.addr];
            end
            if (we)
            begin
                vld_reg[op_reg.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            wr_addr_reg <= op_reg.addr;
            wr_data_reg <= wdata;
        end
    end
endmodule

`default_nettype wire

@@ hw/rtl/bgpw_res_fifo.sv @@
`default_nettype none

module bgpw_res_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [1:0]                     push_cnt,
    input  bgpw_pkg::res_item_t            push0,
    input  bgpw_pkg::res_item_t            push1,
    input  logic                           pop,
    output bgpw_pkg::res_item_t            head,
    output logic [bgpw_pkg::RES_CNT_W-1:0] count
);
    import bgpw_pkg::*;

    res_item_t              ent_reg [RES_FIFO_DEPTH];
    logic [RES_PTR_W-1:0]   wptr_reg, wptr_next;
    logic [RES_PTR_W-1:0]   rptr_reg, rptr_next;
    logic [RES_CNT_W-1:0]   count_reg, count_next;

    assign wptr_next  = wptr_reg + RES_PTR_W'(push_cnt);
    assign rptr_next  = rptr_reg + RES_PTR_W'(pop);
    assign count_next = count_reg + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            ent_reg[wptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            ent_reg[wptr_reg + RES_PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    assign head  = ent_reg[rptr_reg];
    assign count = count_reg;
endmodule

`default_nettype wire

@@ hw/rtl/bgp_attribute_tlv_walker.sv @@
// BGP path-attribute area walker.
// Channel req (sink) carries requests: begin an area of area_length bytes,
// one data byte of the area, or read the counter of a type. Channel res
// (source) carries results: found attribute, short header, short payload,
// area done, or counter value. Both use valid/ready; a transfer happens on
// a rising edge with both high.
// A result reaches res through the parser's result stage and then the
// 4-entry result queue in front of the single res port. Throughput: one
// request per cycle while req.ready is high. Requests that give no result
// (most data bytes) stall only while the result queue is backed up.
// Results leave at one per cycle; a request that gives two results (error
// or found on the last byte of an area) pushes both into the queue.
// Per-type counters live in a 256-entry single-read RAM; an increment is a
// read on the request cycle and a write in the next cycle, with the previous
// write forwarded. Reset leaves the walker idle and all counters reading
// zero at once through per-entry valid bits; there is no clearing pass.
// When res stalls, results wait in the queue and req.ready drops once the
// queue and the result stage hold three or more results.
`default_nettype none

module bgp_attribute_tlv_walker #(
    parameter int COUNT_WIDTH = 32
) (
    input logic            clk,
    input logic            rst_n,
    bgpw_stream_if.sink    req,
    bgpw_stream_if.source  res
);
    import bgpw_pkg::*;

    localparam int SUM_W = RES_CNT_W + 1;

    logic                    accept;
    cnt_op_t                 op;
    stage_t                  stage;
    logic [TYPE_COUNT_W-1:0] count;
    res_item_t               push0;
    res_item_t               head;
    logic [RES_CNT_W-1:0]    fifo_count;
    logic                    pop;
    logic [SUM_W-1:0]        pending;

    assign pending   = SUM_W'(fifo_count) + SUM_W'(stage.res_cnt);
    assign req.ready = (pending <= SUM_W'(RES_FIFO_DEPTH - 2));
    assign accept    = req.valid && req.ready;

    bgpw_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .item  (req.payload),
        .op    (op),
        .stage (stage)
    );

    bgpw_cnt_bank #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cnt_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .count (count)
    );

    always_comb
    begin
        push0 = stage.res0;
        if (stage.res0.kind == KIND_COUNT)
        begin
            push0.type_count = count;
        end
    end

    bgpw_res_fifo u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (stage.res_cnt),
        .push0    (push0),
        .push1    (stage.res1),
        .pop      (pop),
        .head     (head),
        .count    (fifo_count)
    );

    assign res.valid   = (fifo_count != '0);
    assign res.payload = head;
    assign pop         = res.valid && res.ready;

    a_read_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.payload.command == CMD_READ))
        |=> (stage.res_cnt == 2'd1) && (stage.res0.kind == KIND_COUNT))
        else $error("read request did not produce a count result");

    a_empty_area: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.payload.command == CMD_BEGIN) && (req.payload.area_length == 16'd0))
        |=> (stage.res_cnt == 2'd1) && (stage.res0.kind == KIND_DONE) && stage.res0.last)
        else $error("empty area did not report done");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        pending <= SUM_W'(RES_FIFO_DEPTH))
        else $error("result queue overflow");

    a_second_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (stage.res_cnt == 2'd2) |-> (stage.res1.kind == KIND_DONE) && stage.res1.last
                                    && (stage.res0.kind != KIND_DONE))
        else $error("second result of a request is not area done");
endmodule

`default_nettype wire
